>>> src/mbet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_pkg
// Shared widths, types and arithmetic helpers for the escape-time counter.
// ----------------------------------------------------------------------------
package mbet_pkg;

	localparam int DATA_W     = 32;
	localparam int FRAC_BITS  = 28;
	localparam int COUNT_BITS = 16;
	localparam int ITER_W     = 16;
	localparam int CFG_W      = 16;
	localparam int PROD_W     = 2 * DATA_W;

	// Width that holds squares, cross term and sums without overflow
	localparam int SUM_A = 2 * DATA_W - FRAC_BITS + 2;
	localparam int SUM_B = (DATA_W + 2 > FRAC_BITS + 4) ? DATA_W + 2 : FRAC_BITS + 4;
	localparam int SUM_W = (SUM_A > SUM_B) ? SUM_A : SUM_B;

	localparam logic [CFG_W-1:0] MAX_ITER_RST = CFG_W'(1000);

	localparam logic signed [SUM_W-1:0] FOUR = SUM_W'(4) << FRAC_BITS;
	localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_TEST,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic upd;
		logic publish;
	} cmd_t;

	typedef struct packed {
		logic lim_zero;
		logic escape;
		logic last;
	} sts_t;

	// Clamp to the signed data range
	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(DATA_MAX);
		lo = SUM_W'(DATA_MIN);
		if (v > hi) begin
			return DATA_MAX;
		end else if (v < lo) begin
			return DATA_MIN;
		end
		return DATA_W'(v);
	endfunction

	// Limit the register value to what the counter can hold
	function automatic logic [COUNT_BITS-1:0] clamp_limit(input logic [CFG_W-1:0] v);
		logic [63:0] w;
		logic [63:0] cap;
		w   = 64'(v);
		cap = (64'(1) << COUNT_BITS) - 64'(1);
		if (w > cap) begin
			w = cap;
		end
		return COUNT_BITS'(w);
	endfunction

endpackage

>>> src/mbet_point_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_point_if
// Input channel: one point c per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mbet_point_if import mbet_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] c_real;
	logic signed [DATA_W-1:0] c_imag;

	modport source (output valid, output c_real, output c_imag, input ready);
	modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

>>> src/mbet_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_result_if
// Output channel: one iteration count per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mbet_result_if import mbet_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ITER_W-1:0] iterations;

	modport source (output valid, output iterations, input ready);
	modport sink   (input valid, input iterations, output ready);
endinterface

>>> src/mbet_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_dp
// Iterate registers, product stage, escape test, update and result register.
// ----------------------------------------------------------------------------
module mbet_dp import mbet_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	input  logic signed [DATA_W-1:0] c_real,
	input  logic signed [DATA_W-1:0] c_imag,
	input  logic                     cfg_wen,
	input  logic [CFG_W-1:0]         cfg_wdata,
	output sts_t                     sts,
	output logic [ITER_W-1:0]        iterations
);

	logic [CFG_W-1:0]         max_iter_q;
	logic signed [DATA_W-1:0] cr_q, ci_q, re_q, im_q;
	logic [COUNT_BITS-1:0]    cnt_q, lim_q;
	logic signed [PROD_W-1:0] sq_re_s1, sq_im_s1, x_s1;
	logic [ITER_W-1:0]        res_q;

	logic signed [SUM_W-1:0]  r2, i2, two_ri, mag2;
	logic signed [SUM_W-1:0]  re_nxt, im_nxt;
	logic [COUNT_BITS:0]      cnt_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= MAX_ITER_RST;
		end else if (cfg_wen) begin
			max_iter_q <= cfg_wdata;
		end
	end

	// Truncating shifts of the registered products
	always_comb begin
		r2      = SUM_W'(sq_re_s1 >>> FRAC_BITS);
		i2      = SUM_W'(sq_im_s1 >>> FRAC_BITS);
		two_ri  = SUM_W'(x_s1 >>> (FRAC_BITS - 1));
		mag2    = r2 + i2;
		re_nxt  = r2 - i2 + SUM_W'(cr_q);
		im_nxt  = two_ri + SUM_W'(ci_q);
		cnt_inc = {1'b0, cnt_q} + (COUNT_BITS+1)'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cr_q  <= c_real;
			ci_q  <= c_imag;
			re_q  <= c_real;
			im_q  <= c_imag;
			cnt_q <= '0;
			lim_q <= clamp_limit(max_iter_q);
		end
		if (cmd.mul) begin
			sq_re_s1 <= re_q * re_q;
			sq_im_s1 <= im_q * im_q;
			x_s1     <= re_q * im_q;
		end
		if (cmd.upd) begin
			re_q  <= sat_data(re_nxt);
			im_q  <= sat_data(im_nxt);
			cnt_q <= COUNT_BITS'(cnt_inc);
		end
		if (cmd.publish) begin
			res_q <= ITER_W'(cnt_q);
		end
	end

	assign sts.lim_zero = (clamp_limit(max_iter_q) == '0);
	assign sts.escape   = (mag2 > FOUR);
	assign sts.last     = (cnt_inc == {1'b0, lim_q});
	assign iterations   = res_q;

endmodule

>>> src/mbet_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_ctrl
// Sequencer for the escape-time loop and the output holding flag.
// ----------------------------------------------------------------------------
module mbet_ctrl import mbet_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nxt;
	logic   res_vld_q;
	logic   out_busy;

	assign out_busy  = res_vld_q && !out_ready;
	assign out_valid = res_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			res_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.publish) begin
				res_vld_q <= 1'b1;
			end else if (out_ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = sts.lim_zero ? ST_FIN : ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_TEST;
			end
			ST_TEST: begin
				if (sts.escape) begin
					state_nxt = ST_FIN;
				end else begin
					cmd.upd   = 1'b1;
					state_nxt = sts.last ? ST_FIN : ST_MUL;
				end
			end
			ST_FIN: begin
				// wait for the holding register to free up
				if (!out_busy) begin
					cmd.publish = 1'b1;
					state_nxt   = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

>>> src/mandelbrot_escape_time.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time iteration count for one point c in signed Q4.28.
// ----------------------------------------------------------------------------
// Usage:
//   point  : sink channel, one item = (c_real, c_imag), taken when valid and
//            ready are both high. Ready is high only while the loop is idle.
//   result : source channel, one item = iterations, held in an output
//            register until the receiver takes it.
//   cfg_wen/cfg_wdata : write max_iterations; write only while idle.
// Timing:
//   In each iteration ST_MUL registers the three 32x32 products and
//   ST_TEST then tests |z|^2 against 4 and, if it has not escaped,
//   updates z and the count. After the final test, or when the limit
//   is zero, ST_FIN publishes the count into the output register; a
//   point that never escapes stops after limit iterations. The next point
//   may be taken the cycle after the result is published.
// Reset:
//   arst_n clears the sequencer and the output flag and sets max_iterations
//   to 1000.
// Stall:
//   A waiting result does not block the next point; if the loop finishes
//   again before the old result is taken, it holds in the publish state.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time import mbet_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	mbet_point_if.sink          point,
	mbet_result_if.source       result,
	input  logic                cfg_wen,
	input  logic [CFG_W-1:0]    cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer: owns handshakes and drives the datapath commands
	mbet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (point.valid),
		.in_ready  (point.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: iterate, products, escape test and result register
	mbet_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.c_real     (point.c_real),
		.c_imag     (point.c_imag),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.sts        (sts),
		.iterations (result.iterations)
	);

endmodule

>>> src/mbet_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_checker
// Port-level checks for the escape-time counter, bound to the top level.
// ----------------------------------------------------------------------------
module mbet_checker import mbet_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [ITER_W-1:0] iterations
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(iterations))
		else $error("result changed while stalled");

	// one point at a time: ready drops after an accept
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second point taken while busy");

	// a new result never appears the cycle after an accept
	a_min_lat: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result too early");

endmodule

bind mandelbrot_escape_time mbet_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (point.valid),
	.in_ready   (point.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.iterations (result.iterations)
);
